// ===== src/itt_pkg.sv =====
package itt_pkg;

   // field widths
   localparam int RAW_W   = 12;
   localparam int TEMP_W  = 14;
   localparam int SP_W    = 10;
   localparam int CAL_W   = 10;
   localparam int SET_W   = 9;
   localparam int SLEEP_W = 9;
   localparam int BOOST_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // register reset values
   localparam logic [CAL_W-1:0]   CAL_LOW_RESET  = 10'd200;
   localparam logic [CAL_W-1:0]   CAL_MID_RESET  = 10'd280;
   localparam logic [CAL_W-1:0]   CAL_HIGH_RESET = 10'd360;
   localparam logic [SLEEP_W-1:0] SLEEP_RESET    = 9'd150;
   localparam logic [BOOST_W-1:0] BOOST_RESET    = 8'd50;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_LOW  = 3'd0,
      CSR_CAL_MID  = 3'd1,
      CSR_CAL_HIGH = 3'd2,
      CSR_SLEEP    = 3'd3,
      CSR_BOOST    = 3'd4
   } itt_csr_type;

   // smoothing: trunc(d / 20) as (|d| * 3277) >> 16, exact for |d| < 4096
   localparam logic [RAW_W-1:0] DIV20_MUL   = 12'd3277;
   localparam int               DIV20_SHIFT = 16;
   localparam int               STEP_W      = 8;

   // calibration knots on the raw axis
   localparam logic [RAW_W-1:0] RAW_KNEE_LOW  = 12'd418;
   localparam logic [RAW_W-1:0] RAW_KNEE_MID  = 12'd823;
   localparam logic [RAW_W-1:0] RAW_KNEE_HIGH = 12'd1242;

   // fixed part of the curve
   localparam logic [CAL_W-1:0]        Y_COLD_BASE  = 10'd21;
   localparam logic signed [CAL_W:0]   Y_COLD_SLOPE = 11'sd89;
   localparam logic [CAL_W-1:0]        Y_LOW_BASE   = 10'd111;

   // segment spans (raw distance between knots)
   localparam longint unsigned SPAN_COLD = 418;
   localparam longint unsigned SPAN_LOW  = 405;
   localparam longint unsigned SPAN_MID  = 419;
   localparam longint unsigned SPAN_HIGH = 408;

   // reciprocals of the spans, ceil(2^31 / span); exact for products below 2^22
   localparam int NUM_W       = 22;
   localparam int RECIP_SHIFT = 31;
   localparam int RECIP_W     = 23;
   localparam int QUOT_W      = 13;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_COLD =
      RECIP_W'((RECIP_ONE + SPAN_COLD - 1) / SPAN_COLD);
   localparam logic [RECIP_W-1:0] RECIP_LOW  =
      RECIP_W'((RECIP_ONE + SPAN_LOW - 1) / SPAN_LOW);
   localparam logic [RECIP_W-1:0] RECIP_MID  =
      RECIP_W'((RECIP_ONE + SPAN_MID - 1) / SPAN_MID);
   localparam logic [RECIP_W-1:0] RECIP_HIGH =
      RECIP_W'((RECIP_ONE + SPAN_HIGH - 1) / SPAN_HIGH);

   // calibration segment
   typedef enum logic [1:0] {
      SEG_COLD = 2'd0,
      SEG_LOW  = 2'd1,
      SEG_MID  = 2'd2,
      SEG_HIGH = 2'd3
   } itt_seg_type;

   // tip thresholds and windows
   localparam logic signed [TEMP_W-1:0] TIP_LIMIT  = 14'sd500;
   localparam logic signed [TEMP_W:0]   SNAP_KEEP  = 15'sd5;
   localparam logic signed [TEMP_W:0]   SNAP_NEAR  = 15'sd1;
   localparam logic signed [TEMP_W:0]   AT_WINDOW  = 15'sd5;

   // mode and set temperature that follow a sample down the pipe
   typedef struct packed {
      logic [SET_W-1:0] set_temp;
      logic             off_mode;
      logic             sleep_mode;
      logic             boost_mode;
      logic             rearm_beep;
   } itt_ctl_type;

   // upper calibration points
   typedef struct packed {
      logic [CAL_W-1:0] low;
      logic [CAL_W-1:0] mid;
      logic [CAL_W-1:0] high;
   } itt_cal_cfg_type;

endpackage

// ===== src/itt_cal.sv =====
// raw to degrees: two pipeline stages, numerator product then reciprocal divide
module itt_cal (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [itt_pkg::RAW_W-1:0]            in_raw,
   input  itt_pkg::itt_ctl_type                 in_ctl,
   input  itt_pkg::itt_cal_cfg_type             cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [itt_pkg::TEMP_W-1:0]    out_temp,
   output itt_pkg::itt_ctl_type                 out_ctl
);

   logic                               s2_valid_ff, s2_valid_in;
   logic [itt_pkg::NUM_W-1:0]          s2_num_ff, num_in;
   logic                               s2_neg_ff;
   logic [itt_pkg::CAL_W-1:0]          s2_y0_ff, y0_in;
   itt_pkg::itt_seg_type               s2_seg_ff, seg_in;
   itt_pkg::itt_ctl_type               s2_ctl_ff;

   logic                               s3_valid_ff, s3_valid_in;
   logic                               s3_ready;
   logic signed [itt_pkg::TEMP_W-1:0]  s3_temp_ff, temp_in;
   itt_pkg::itt_ctl_type               s3_ctl_ff;

   logic [itt_pkg::RAW_W-1:0]          dx_in;
   logic signed [itt_pkg::CAL_W:0]     dy_in, dy_neg;
   logic [itt_pkg::CAL_W-1:0]          mag_in;

   logic [itt_pkg::RECIP_W-1:0]        recip;
   logic [itt_pkg::PROD_W-1:0]         prod;
   logic [itt_pkg::QUOT_W-1:0]         quot;
   logic signed [itt_pkg::TEMP_W-1:0]  y0_s, quot_s;

   // handshake between the two stages
   assign s3_ready    = !s3_valid_ff || out_ready;
   assign in_ready    = !s2_valid_ff || s3_ready;
   assign s2_valid_in = in_ready ? in_valid : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // segment select, offset along the segment and slope
   always_comb begin
      if (in_raw < itt_pkg::RAW_KNEE_LOW) begin
         seg_in = itt_pkg::SEG_COLD;
      end else if (in_raw < itt_pkg::RAW_KNEE_MID) begin
         seg_in = itt_pkg::SEG_LOW;
      end else if (in_raw < itt_pkg::RAW_KNEE_HIGH) begin
         seg_in = itt_pkg::SEG_MID;
      end else begin
         seg_in = itt_pkg::SEG_HIGH;
      end
      unique case (seg_in)
         itt_pkg::SEG_COLD: begin
            dx_in = in_raw;
            dy_in = itt_pkg::Y_COLD_SLOPE;
            y0_in = itt_pkg::Y_COLD_BASE;
         end
         itt_pkg::SEG_LOW: begin
            dx_in = in_raw - itt_pkg::RAW_KNEE_LOW;
            dy_in = $signed({1'b0, cfg.low}) - $signed({1'b0, itt_pkg::Y_LOW_BASE});
            y0_in = itt_pkg::Y_LOW_BASE;
         end
         itt_pkg::SEG_MID: begin
            dx_in = in_raw - itt_pkg::RAW_KNEE_MID;
            dy_in = $signed({1'b0, cfg.mid}) - $signed({1'b0, cfg.low});
            y0_in = cfg.low;
         end
         default: begin
            dx_in = in_raw - itt_pkg::RAW_KNEE_HIGH;
            dy_in = $signed({1'b0, cfg.high}) - $signed({1'b0, cfg.mid});
            y0_in = cfg.mid;
         end
      endcase
   end

   // offset is never negative, so the sign rides on the slope alone
   assign dy_neg = -dy_in;
   assign mag_in = dy_in[itt_pkg::CAL_W] ? dy_neg[itt_pkg::CAL_W-1:0]
                                         : dy_in[itt_pkg::CAL_W-1:0];
   assign num_in = {{(itt_pkg::NUM_W-itt_pkg::RAW_W){1'b0}}, dx_in}
                   * {{(itt_pkg::NUM_W-itt_pkg::CAL_W){1'b0}}, mag_in};

   // divide by the segment span through its reciprocal
   always_comb begin
      unique case (s2_seg_ff)
         itt_pkg::SEG_COLD: recip = itt_pkg::RECIP_COLD;
         itt_pkg::SEG_LOW:  recip = itt_pkg::RECIP_LOW;
         itt_pkg::SEG_MID:  recip = itt_pkg::RECIP_MID;
         default:           recip = itt_pkg::RECIP_HIGH;
      endcase
   end

   assign prod   = {{itt_pkg::RECIP_W{1'b0}}, s2_num_ff} * {{itt_pkg::NUM_W{1'b0}}, recip};
   assign quot   = prod[itt_pkg::RECIP_SHIFT +: itt_pkg::QUOT_W];
   assign y0_s   = $signed({{(itt_pkg::TEMP_W-itt_pkg::CAL_W){1'b0}}, s2_y0_ff});
   assign quot_s = $signed({{(itt_pkg::TEMP_W-itt_pkg::QUOT_W){1'b0}}, quot});
   // the curve stays within -6130..7153, inside the result range
   assign temp_in = s2_neg_ff ? (y0_s - quot_s) : (y0_s + quot_s);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_num_ff <= num_in;
         s2_neg_ff <= dy_in[itt_pkg::CAL_W];
         s2_y0_ff  <= y0_in;
         s2_seg_ff <= seg_in;
         s2_ctl_ff <= in_ctl;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_temp_ff <= temp_in;
         s3_ctl_ff  <= s2_ctl_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_temp  = s3_temp_ff;
   assign out_ctl   = s3_ctl_ff;

endmodule

// ===== src/iron_temperature_thermostat.sv =====
// Soldering-iron tip thermostat. One tip ADC sample is accepted per beat on the
// req_ channel and exactly one result beat leaves on rsp_ for each, in order.
// Samples can be accepted every cycle unless the result side stalls; each passes
// the input register with the smoothing recurrence, two calibration stages
// holding the span multiply and the reciprocal divide, and the result register
// that closes the display, beep and tip-detect state. Calibration points, sleep
// and boost temperatures are written through csr_ by the user, only while no
// sample is in flight, not enforced by the block; reset values apply otherwise.
module iron_temperature_thermostat (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [itt_pkg::RAW_W-1:0]           req_adc_sample,
   input  logic [itt_pkg::SET_W-1:0]           req_set_temp,
   input  logic                                req_off_mode,
   input  logic                                req_sleep_mode,
   input  logic                                req_boost_mode,
   input  logic                                req_rearm_beep,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [itt_pkg::TEMP_W-1:0]   rsp_current_temp,
   output logic signed [itt_pkg::TEMP_W-1:0]   rsp_display_temp,
   output logic [itt_pkg::SP_W-1:0]            rsp_setpoint,
   output logic                                rsp_heater_on,
   output logic                                rsp_at_temp,
   output logic                                rsp_beep_now,
   output logic                                rsp_tip_inserted,
   output logic                                rsp_tip_present,
   // register writes
   input  logic                                csr_write_en,
   input  logic [itt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [itt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // registers
   itt_pkg::itt_cal_cfg_type          cal_cfg_ff, cal_cfg_in;
   logic [itt_pkg::SLEEP_W-1:0]       sleep_temp_ff, sleep_temp_in;
   logic [itt_pkg::BOOST_W-1:0]       boost_temp_ff, boost_temp_in;

   // input stage
   logic                              s1_valid_ff, s1_valid_in;
   logic [itt_pkg::RAW_W-1:0]         smoothed_ff, smoothed_in;
   itt_pkg::itt_ctl_type              s1_ctl_ff, req_ctl;
   logic                              req_beat;
   logic signed [itt_pkg::RAW_W:0]    diff, diff_neg;
   logic [itt_pkg::RAW_W-1:0]         diff_mag, step_ext, smoothed_step;
   logic [2*itt_pkg::RAW_W-1:0]       step_prod;

   // calibration
   logic                              cal_in_ready;
   logic                              cal_out_valid, cal_out_ready;
   logic signed [itt_pkg::TEMP_W-1:0] cal_temp;
   itt_pkg::itt_ctl_type              cal_ctl;

   // result stage and running state
   logic                              rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [itt_pkg::TEMP_W-1:0] shown_ff, shown_in;
   logic [itt_pkg::SP_W-1:0]          last_sp_ff, sp_in;
   logic                              working_ff, working_in;
   logic                              armed_ff, armed_in, armed_rearm;
   logic                              tip_ff, tip_in;
   logic signed [itt_pkg::TEMP_W-1:0] rsp_cur_ff, rsp_shown_ff;
   logic [itt_pkg::SP_W-1:0]          rsp_sp_ff;
   logic                              rsp_heat_ff, rsp_at_ff, rsp_beep_ff, rsp_ins_ff;
   logic                              rsp_tip_ff;
   logic signed [itt_pkg::TEMP_W-1:0] prev_sp_s, shown_keep;
   logic signed [itt_pkg::TEMP_W:0]   shown_vs_cur, shown_vs_sp, set_vs_cur;
   logic signed [itt_pkg::TEMP_W:0]   cur_plus, sp_wide;
   logic                              at_in, beep_in, ins_in, heat_in;

   // register writes
   always_comb begin
      cal_cfg_in    = cal_cfg_ff;
      sleep_temp_in = sleep_temp_ff;
      boost_temp_in = boost_temp_ff;
      if (csr_write_en) begin
         unique case (itt_pkg::itt_csr_type'(csr_index))
            itt_pkg::CSR_CAL_LOW:  cal_cfg_in.low  = csr_wdata[itt_pkg::CAL_W-1:0];
            itt_pkg::CSR_CAL_MID:  cal_cfg_in.mid  = csr_wdata[itt_pkg::CAL_W-1:0];
            itt_pkg::CSR_CAL_HIGH: cal_cfg_in.high = csr_wdata[itt_pkg::CAL_W-1:0];
            itt_pkg::CSR_SLEEP:    sleep_temp_in   = csr_wdata[itt_pkg::SLEEP_W-1:0];
            itt_pkg::CSR_BOOST:    boost_temp_in   = csr_wdata[itt_pkg::BOOST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cfg_ff.low  <= itt_pkg::CAL_LOW_RESET;
         cal_cfg_ff.mid  <= itt_pkg::CAL_MID_RESET;
         cal_cfg_ff.high <= itt_pkg::CAL_HIGH_RESET;
         sleep_temp_ff   <= itt_pkg::SLEEP_RESET;
         boost_temp_ff   <= itt_pkg::BOOST_RESET;
      end else begin
         cal_cfg_ff    <= cal_cfg_in;
         sleep_temp_ff <= sleep_temp_in;
         boost_temp_ff <= boost_temp_in;
      end
   end

   // input handshake
   assign req_ready   = !s1_valid_ff || cal_in_ready;
   assign req_beat    = req_valid && req_ready;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   assign req_ctl.set_temp   = req_set_temp;
   assign req_ctl.off_mode   = req_off_mode;
   assign req_ctl.sleep_mode = req_sleep_mode;
   assign req_ctl.boost_mode = req_boost_mode;
   assign req_ctl.rearm_beep = req_rearm_beep;

   // exponential average, step trunc((sample - avg) / 20), or req_op loads; 0..4095
   assign diff          = $signed({1'b0, req_adc_sample}) - $signed({1'b0, smoothed_ff});
   assign diff_neg      = -diff;
   assign diff_mag      = diff[itt_pkg::RAW_W] ? diff_neg[itt_pkg::RAW_W-1:0]
                                               : diff[itt_pkg::RAW_W-1:0];
   assign step_prod     = {{itt_pkg::RAW_W{1'b0}}, diff_mag}
                          * {{itt_pkg::RAW_W{1'b0}}, itt_pkg::DIV20_MUL};
   assign step_ext      = {{(itt_pkg::RAW_W-itt_pkg::STEP_W){1'b0}},
                           step_prod[itt_pkg::DIV20_SHIFT +: itt_pkg::STEP_W]};
   assign smoothed_step = diff[itt_pkg::RAW_W] ? (smoothed_ff - step_ext)
                                               : (smoothed_ff + step_ext);
   assign smoothed_in   = req_op ? req_adc_sample : smoothed_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         smoothed_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_beat) begin
            smoothed_ff <= smoothed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_ctl_ff <= req_ctl;
      end
   end

   // calibration pipeline
   itt_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (cal_in_ready),
      .in_raw    (smoothed_ff),
      .in_ctl    (s1_ctl_ff),
      .cfg       (cal_cfg_ff),
      .out_valid (cal_out_valid),
      .out_ready (cal_out_ready),
      .out_temp  (cal_temp),
      .out_ctl   (cal_ctl)
   );

   // result handshake
   assign cal_out_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_load      = cal_out_valid && cal_out_ready;
   assign rsp_valid_in  = cal_out_ready ? cal_out_valid : rsp_valid_ff;

   // display hysteresis: hold the previous setpoint while close, snap when within one
   assign prev_sp_s    = $signed({{(itt_pkg::TEMP_W-itt_pkg::SP_W){1'b0}}, last_sp_ff});
   assign shown_vs_cur = $signed({shown_ff[itt_pkg::TEMP_W-1], shown_ff})
                         - $signed({cal_temp[itt_pkg::TEMP_W-1], cal_temp});
   assign shown_keep   = ((shown_ff != prev_sp_s) || (shown_vs_cur > itt_pkg::SNAP_KEEP)
                          || (shown_vs_cur < -itt_pkg::SNAP_KEEP)) ? cal_temp : shown_ff;
   assign shown_vs_sp  = $signed({shown_keep[itt_pkg::TEMP_W-1], shown_keep})
                         - $signed({prev_sp_s[itt_pkg::TEMP_W-1], prev_sp_s});
   assign shown_in     = ((shown_vs_sp <= itt_pkg::SNAP_NEAR)
                          && (shown_vs_sp >= -itt_pkg::SNAP_NEAR)) ? prev_sp_s : shown_keep;

   // at-temperature and one-shot beep, rearm counts before the check
   assign set_vs_cur  = $signed({{(itt_pkg::TEMP_W+1-itt_pkg::SET_W){1'b0}},
                                 cal_ctl.set_temp})
                        - $signed({cal_temp[itt_pkg::TEMP_W-1], cal_temp});
   assign at_in       = (set_vs_cur < itt_pkg::AT_WINDOW) && (set_vs_cur > -itt_pkg::AT_WINDOW);
   assign armed_rearm = armed_ff || cal_ctl.rearm_beep;
   assign beep_in     = at_in && !working_ff && armed_rearm;
   assign working_in  = at_in;
   assign armed_in    = at_in ? 1'b0 : armed_rearm;

   // tip removal above the limit, insertion once back below it
   always_comb begin
      ins_in = 1'b0;
      tip_in = tip_ff;
      if (shown_in > itt_pkg::TIP_LIMIT) begin
         tip_in = 1'b0;
      end else if (!tip_ff && (shown_in < itt_pkg::TIP_LIMIT)) begin
         tip_in = 1'b1;
         ins_in = 1'b1;
      end
   end

   // setpoint: off over sleep over boost; boost sum tops out at 766
   always_comb begin
      if (cal_ctl.off_mode) begin
         sp_in = '0;
      end else if (cal_ctl.sleep_mode) begin
         sp_in = {{(itt_pkg::SP_W-itt_pkg::SLEEP_W){1'b0}}, sleep_temp_ff};
      end else if (cal_ctl.boost_mode) begin
         sp_in = {{(itt_pkg::SP_W-itt_pkg::SET_W){1'b0}}, cal_ctl.set_temp}
                 + {{(itt_pkg::SP_W-itt_pkg::BOOST_W){1'b0}}, boost_temp_ff};
      end else begin
         sp_in = {{(itt_pkg::SP_W-itt_pkg::SET_W){1'b0}}, cal_ctl.set_temp};
      end
   end

   // heater full on below setpoint minus one
   assign cur_plus = $signed({cal_temp[itt_pkg::TEMP_W-1], cal_temp})
                     + $signed({{itt_pkg::TEMP_W{1'b0}}, 1'b1});
   assign sp_wide  = $signed({{(itt_pkg::TEMP_W+1-itt_pkg::SP_W){1'b0}}, sp_in});
   assign heat_in  = cur_plus < sp_wide;

   // running state, moves with each result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         shown_ff     <= '0;
         last_sp_ff   <= '0;
         working_ff   <= 1'b1;
         armed_ff     <= 1'b1;
         tip_ff       <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            shown_ff   <= shown_in;
            last_sp_ff <= sp_in;
            working_ff <= working_in;
            armed_ff   <= armed_in;
            tip_ff     <= tip_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cur_ff   <= cal_temp;
         rsp_shown_ff <= shown_in;
         rsp_sp_ff    <= sp_in;
         rsp_heat_ff  <= heat_in;
         rsp_at_ff    <= at_in;
         rsp_beep_ff  <= beep_in;
         rsp_ins_ff   <= ins_in;
         rsp_tip_ff   <= tip_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_temp = rsp_cur_ff;
   assign rsp_display_temp = rsp_shown_ff;
   assign rsp_setpoint     = rsp_sp_ff;
   assign rsp_heater_on    = rsp_heat_ff;
   assign rsp_at_temp      = rsp_at_ff;
   assign rsp_beep_now     = rsp_beep_ff;
   assign rsp_tip_inserted = rsp_ins_ff;
   assign rsp_tip_present  = rsp_tip_ff;

   // average moves only on an accepted sample
   a_smooth_hold: assert property (@(posedge clock) disable iff (reset)
      !req_beat |=> $stable(smoothed_ff))
      else $error("smoothed value changed without a sample beat");

   // display state frozen while a result is stalled
   a_shown_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(shown_ff) && $stable(tip_ff))
      else $error("running state moved while the result was stalled");

   // a beep only ever comes with at-temperature
   a_beep_at: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beep_now) |-> rsp_at_temp)
      else $error("beep without reaching temperature");

   // an insertion leaves the tip present and the display below the limit
   a_tip_ins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tip_inserted) |-> rsp_tip_present
                                          && (rsp_display_temp < itt_pkg::TIP_LIMIT))
      else $error("tip insertion with inconsistent tip state");

endmodule

// ===== tb/iron_temperature_thermostat_test.sv =====
`timescale 1ns / 1ps

module iron_temperature_thermostat_test;

   // one tip sample as driven on the req_ channel
   typedef struct packed {
      logic                        op;
      logic [itt_pkg::RAW_W-1:0]   adc;
      logic [itt_pkg::SET_W-1:0]   set_temp;
      logic                        off_mode;
      logic                        sleep_mode;
      logic                        boost_mode;
      logic                        rearm_beep;
   } sample_type;

   // one thermostat reading as seen on the rsp_ channel
   typedef struct packed {
      logic signed [itt_pkg::TEMP_W-1:0] current_temp;
      logic signed [itt_pkg::TEMP_W-1:0] display_temp;
      logic [itt_pkg::SP_W-1:0]          setpoint;
      logic                              heater_on;
      logic                              at_temp;
      logic                              beep_now;
      logic                              tip_inserted;
      logic                              tip_present;
   } reading_type;

   // directed row: sample, and a reading typed in when it is obvious
   typedef struct packed {
      sample_type  s;
      logic        typed;
      reading_type want;
   } stim_row_type;

   // calibration knots and fixed curve points
   localparam int KNEE_COLD   = 418;
   localparam int KNEE_LOW    = 823;
   localparam int KNEE_MID    = 1242;
   localparam int KNEE_HIGH   = 1650;
   localparam int COLD_Y0     = 21;
   localparam int COLD_Y1     = 110;
   localparam int LOW_Y0      = 111;
   localparam int TIP_EDGE    = 500;
   localparam int SP_MAX      = (1 << itt_pkg::SP_W) - 1;
   localparam int TEMP_LO     = -(1 << (itt_pkg::TEMP_W - 1));
   localparam int TEMP_HI     = (1 << (itt_pkg::TEMP_W - 1)) - 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_DIRECTED = 25;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   sample_type                        drv_sample = '0;
   logic                              drv_typed = 1'b0;
   reading_type                       drv_want = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [itt_pkg::TEMP_W-1:0] rsp_current_temp;
   logic signed [itt_pkg::TEMP_W-1:0] rsp_display_temp;
   logic [itt_pkg::SP_W-1:0]          rsp_setpoint;
   logic                              rsp_heater_on;
   logic                              rsp_at_temp;
   logic                              rsp_beep_now;
   logic                              rsp_tip_inserted;
   logic                              rsp_tip_present;
   logic                              csr_write_en = 1'b0;
   logic [itt_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [itt_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   // thermostat copy: registers and running state
   int cal_low, cal_mid, cal_high, sleep_setting, boost_setting;
   int smooth_raw, shown, last_sp;
   bit working_flag, beep_armed, tip_flag;

   reading_type expected_readings[$];
   bit          failed = 1'b0;
   int          idle_cycles = 0;
   int          burst_left = 0;

   // directed samples: after reset, extremes, beep, hysteresis, tip, modes, knees
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{1'b1, 12'd0, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{14'sd21, 14'sd21, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b1, 12'd4095, 9'd511, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{14'sd839, 14'sd839, 10'd561, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{1'b1, 12'd0, 9'd21, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{14'sd21, 14'sd21, 10'd21, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{1'b1, 12'd0, 9'd21, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{14'sd21, 14'sd21, 10'd21, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{1'b1, 12'd0, 9'd21, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b1, 12'd0, 9'd100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd0, 9'd21, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b1, 12'd0, 9'd23, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd0, 9'd22, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd372, 9'd100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd395, 9'd100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd400, 9'd100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd377, 9'd100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd2364, 9'd200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd2600, 9'd200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 12'd0, 9'd200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 12'd0, 9'd200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd1000, 9'd300, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd1000, 9'd300, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd823, 9'd511, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, 12'd4095, 9'd511, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd1242, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd418, 9'd111, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd1650, 9'd360, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 12'd417, 9'd110, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
   };

   iron_temperature_thermostat u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (drv_sample.op),
      .req_adc_sample   (drv_sample.adc),
      .req_set_temp     (drv_sample.set_temp),
      .req_off_mode     (drv_sample.off_mode),
      .req_sleep_mode   (drv_sample.sleep_mode),
      .req_boost_mode   (drv_sample.boost_mode),
      .req_rearm_beep   (drv_sample.rearm_beep),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_current_temp (rsp_current_temp),
      .rsp_display_temp (rsp_display_temp),
      .rsp_setpoint     (rsp_setpoint),
      .rsp_heater_on    (rsp_heater_on),
      .rsp_at_temp      (rsp_at_temp),
      .rsp_beep_now     (rsp_beep_now),
      .rsp_tip_inserted (rsp_tip_inserted),
      .rsp_tip_present  (rsp_tip_present),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int spread(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // straight line through two knots, quotient truncated toward zero
   function automatic int on_segment(int x, int x0, int x1, int y0, int y1);
      return (x - x0) * (y1 - y0) / (x1 - x0) + y0;
   endfunction

   // four-segment calibration, last segment extended past the high knot
   function automatic int raw_to_degrees(int raw);
      int deg;
      if (raw < KNEE_COLD)
         deg = on_segment(raw, 0, KNEE_COLD, COLD_Y0, COLD_Y1);
      else if (raw < KNEE_LOW)
         deg = on_segment(raw, KNEE_COLD, KNEE_LOW, LOW_Y0, cal_low);
      else if (raw < KNEE_MID)
         deg = on_segment(raw, KNEE_LOW, KNEE_MID, cal_low, cal_mid);
      else
         deg = on_segment(raw, KNEE_MID, KNEE_HIGH, cal_mid, cal_high);
      return clamp(deg, TEMP_LO, TEMP_HI);
   endfunction

   // one thermostat update for an accepted sample
   function automatic reading_type thermostat_step(sample_type s);
      int          diff, next_raw, cur, prev_sp, sp, set_t;
      bit          at, beep, inserted;
      reading_type r;
      beep = 1'b0;
      inserted = 1'b0;
      set_t = int'(s.set_temp);
      if (s.rearm_beep) beep_armed = 1'b1;

      // exponential smoothing or direct load
      if (s.op) begin
         smooth_raw = int'(s.adc);
      end else begin
         diff = int'(s.adc) - smooth_raw;
         next_raw = smooth_raw + (diff * 5) / 100;
         if (next_raw < 0) next_raw = 0;
         smooth_raw = next_raw & 'h1FFF;
      end
      cur = raw_to_degrees(smooth_raw);
      prev_sp = last_sp;

      // display hysteresis around the previous setpoint
      if (shown != prev_sp || spread(shown, cur) > 5) shown = cur;
      if (spread(shown, prev_sp) <= 1) shown = prev_sp;

      // at-temperature and one-shot beep
      at = spread(set_t, cur) < 5;
      if (at) begin
         beep = !working_flag && beep_armed;
         working_flag = 1'b1;
         beep_armed = 1'b0;
      end else begin
         working_flag = 1'b0;
      end

      // tip removal above the edge, insertion below it
      if (shown > TIP_EDGE) tip_flag = 1'b0;
      if (!tip_flag && shown < TIP_EDGE) begin
         tip_flag = 1'b1;
         inserted = 1'b1;
      end

      // setpoint: off over sleep over boost
      if (s.off_mode) sp = 0;
      else if (s.sleep_mode) sp = sleep_setting;
      else if (s.boost_mode) sp = set_t + boost_setting;
      else sp = set_t;
      if (sp > SP_MAX) sp = SP_MAX;
      last_sp = sp;

      r.current_temp = cur[itt_pkg::TEMP_W-1:0];
      r.display_temp = shown[itt_pkg::TEMP_W-1:0];
      r.setpoint     = sp[itt_pkg::SP_W-1:0];
      r.heater_on    = cur + 1 < sp;
      r.at_temp      = at;
      r.beep_now     = beep;
      r.tip_inserted = inserted;
      r.tip_present  = tip_flag;
      return r;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         failed = 1'b1;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // observe beats and register writes at every edge
   always @(posedge clock) begin : beat_monitor
      reading_type got, want;
      bit          moved;
      moved = 1'b0;
      if (reset) begin
         cal_low = int'(itt_pkg::CAL_LOW_RESET);
         cal_mid = int'(itt_pkg::CAL_MID_RESET);
         cal_high = int'(itt_pkg::CAL_HIGH_RESET);
         sleep_setting = int'(itt_pkg::SLEEP_RESET);
         boost_setting = int'(itt_pkg::BOOST_RESET);
         smooth_raw = 0;
         shown = 0;
         last_sp = 0;
         working_flag = 1'b1;
         beep_armed = 1'b1;
         tip_flag = 1'b1;
         idle_cycles = 0;
      end else begin
         // register writes
         if (csr_write_en) begin
            case (itt_pkg::itt_csr_type'(csr_index))
               itt_pkg::CSR_CAL_LOW:
                  cal_low = int'(csr_wdata[itt_pkg::CAL_W-1:0]);
               itt_pkg::CSR_CAL_MID:
                  cal_mid = int'(csr_wdata[itt_pkg::CAL_W-1:0]);
               itt_pkg::CSR_CAL_HIGH:
                  cal_high = int'(csr_wdata[itt_pkg::CAL_W-1:0]);
               itt_pkg::CSR_SLEEP:
                  sleep_setting = int'(csr_wdata[itt_pkg::SLEEP_W-1:0]);
               itt_pkg::CSR_BOOST:
                  boost_setting = int'(csr_wdata[itt_pkg::BOOST_W-1:0]);
               default: ;
            endcase
         end

         // result beat against the oldest expected reading
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_readings.size() == 0) begin
               failed = 1'b1;
               $display("%0t: result beat with no sample pending, expected none, actual %0d",
                        $time, rsp_current_temp);
            end else begin
               want = expected_readings.pop_front();
               compare_field("current_temp", int'(want.current_temp),
                             int'(rsp_current_temp));
               compare_field("display_temp", int'(want.display_temp),
                             int'(rsp_display_temp));
               compare_field("setpoint", int'(want.setpoint), int'(rsp_setpoint));
               compare_field("heater_on", int'(want.heater_on), int'(rsp_heater_on));
               compare_field("at_temp", int'(want.at_temp), int'(rsp_at_temp));
               compare_field("beep_now", int'(want.beep_now), int'(rsp_beep_now));
               compare_field("tip_inserted", int'(want.tip_inserted),
                             int'(rsp_tip_inserted));
               compare_field("tip_present", int'(want.tip_present),
                             int'(rsp_tip_present));
            end
         end

         // sample beat: step the thermostat copy
         if (req_valid && req_ready) begin
            moved = 1'b1;
            got = thermostat_step(drv_sample);
            expected_readings.push_back(drv_typed ? drv_want : got);
         end

         // watchdog on cycles without any beat
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // result side backpressure: short stalls, a few long ones, some free runs
   always @(posedge clock) begin : rsp_throttle
      int stall_left, free_left, pick;
      if (free_left > 0) begin
         free_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            free_left = $urandom_range(30, 150);
            rsp_ready <= 1'b1;
         end else if (pick < 60) begin
            rsp_ready <= 1'b1;
         end else if (pick < 92) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            stall_left = $urandom_range(5, 25);
            rsp_ready <= 1'b0;
         end
      end
   end

   // sender gap before the next beat, with bursts of back-to-back beats
   function automatic int pick_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         burst_left = $urandom_range(20, 100);
         return 0;
      end
      if (pick < 58) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   // present one sample and hold it until the beat is taken
   task automatic send_sample(sample_type s, logic typed, reading_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      drv_sample <= s;
      drv_typed <= typed;
      drv_want <= want;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // stop sending and wait until every reading has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // write all five registers on consecutive edges
   task automatic program_registers(int low, int mid, int high, int sleep_v, int boost_v);
      int                   vals[5];
      itt_pkg::itt_csr_type order[5];
      vals = '{low, mid, high, sleep_v, boost_v};
      order = '{itt_pkg::CSR_CAL_LOW, itt_pkg::CSR_CAL_MID, itt_pkg::CSR_CAL_HIGH,
                itt_pkg::CSR_SLEEP, itt_pkg::CSR_BOOST};
      for (int i = 0; i < 5; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i][itt_pkg::CSR_DATA_W-1:0];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // heating sessions: settle on a raw level, set temp near its degrees
   task automatic run_random(int count);
      sample_type s;
      int         level, deg, base_set, session_left, pick, adc_v, set_v;
      logic       run_off, run_sleep, run_boost, load_first;
      bit [31:0]  noise;
      session_left = 0;
      level = 0;
      base_set = 0;
      run_off = 1'b0;
      run_sleep = 1'b0;
      run_boost = 1'b0;
      load_first = 1'b0;
      repeat (count) begin
         // new session
         if (session_left == 0) begin
            session_left = $urandom_range(8, 60);
            pick = $urandom_range(0, 99);
            if (pick < 40) level = $urandom_range(0, 4095);
            else if (pick < 75) level = $urandom_range(0, KNEE_MID);
            else level = $urandom_range(1900, 2900);
            deg = raw_to_degrees(level);
            if (deg >= 0 && deg <= 511)
               base_set = clamp(deg + int'($urandom_range(0, 12)) - 6, 0, 511);
            else
               base_set = $urandom_range(0, 511);
            pick = $urandom_range(0, 99);
            run_off = pick < 10;
            run_sleep = pick >= 10 && pick < 25;
            run_boost = pick >= 20 && pick < 45;
            load_first = $urandom_range(0, 1) == 1;
         end
         session_left--;

         // mostly session samples, some pure noise
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            noise = $urandom();
            s = noise[$bits(sample_type)-1:0];
         end else begin
            adc_v = clamp(level + int'($urandom_range(0, 40)) - 20, 0, 4095);
            if (pick < 70) set_v = base_set;
            else set_v = clamp(base_set + int'($urandom_range(0, 20)) - 10, 0, 511);
            s.op = load_first || ($urandom_range(0, 99) < 3);
            s.adc = adc_v[itt_pkg::RAW_W-1:0];
            s.set_temp = set_v[itt_pkg::SET_W-1:0];
            s.off_mode = run_off ^ ($urandom_range(0, 49) == 0);
            s.sleep_mode = run_sleep ^ ($urandom_range(0, 49) == 0);
            s.boost_mode = run_boost ^ ($urandom_range(0, 49) == 0);
            s.rearm_beep = $urandom_range(0, 9) == 0;
            load_first = 1'b0;
         end
         send_sample(s, 1'b0, '0);
      end
   endtask

   // reset, directed table, then random phases over register settings
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);
      run_random(225);

      settle();
      program_registers(1023, 1023, 1023, 511, 255);
      run_random(225);

      settle();
      program_registers(0, 0, 0, 0, 0);
      run_random(200);

      settle();
      program_registers(0, 1023, 0, 511, 0);
      run_random(200);

      repeat (2) begin
         settle();
         program_registers($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 511),
                           $urandom_range(0, 255));
         run_random(250);
      end

      settle();
      if (!failed)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
